// ===== rtl/utx_pkg.sv =====
// ----------------------------------------------------------------------------
// utx_pkg - shared types and helpers for the UTF-16LE to UTF-8 transcoder
// Holds the queue entry layout, the surrogate and encoding constants, and the
// code point encoder used by the front end.
// ----------------------------------------------------------------------------
package utx_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
	localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
	localparam logic [20:0] PLANE_BASE      = 21'h10000;
	localparam logic [20:0] ONE_BYTE_LIMIT  = 21'h80;
	localparam logic [20:0] TWO_BYTE_LIMIT  = 21'h800;
	localparam logic [7:0]  LEAD2           = 8'hC0;
	localparam logic [7:0]  LEAD3           = 8'hE0;
	localparam logic [7:0]  LEAD4           = 8'hF0;
	localparam logic [7:0]  CONT_MARK       = 8'h80;

	// one encoded code point: bytes in send order, index of its final byte,
	// and whether it closes the string
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            last;
	} seq_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] cont_byte(input logic [5:0] bits);
		cont_byte = CONT_MARK | {2'b00, bits};
	endfunction

	function automatic seq_t encode_point(input logic [20:0] cp, input logic last);
		seq_t s;
		s.bytes = '0;
		s.last = last;
		if (cp < ONE_BYTE_LIMIT) begin
			s.bytes[0] = cp[7:0];
			s.last_idx = 2'd0;
		end else if (cp < TWO_BYTE_LIMIT) begin
			s.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
			s.bytes[1] = cont_byte(cp[5:0]);
			s.last_idx = 2'd1;
		end else if (cp < PLANE_BASE) begin
			s.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
			s.bytes[1] = cont_byte(cp[11:6]);
			s.bytes[2] = cont_byte(cp[5:0]);
			s.last_idx = 2'd2;
		end else begin
			s.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
			s.bytes[1] = cont_byte(cp[17:12]);
			s.bytes[2] = cont_byte(cp[11:6]);
			s.bytes[3] = cont_byte(cp[5:0]);
			s.last_idx = 2'd3;
		end
		return s;
	endfunction

endpackage

// ===== rtl/utf16le_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder - UTF-16 code units in, UTF-8 bytes out
// Top level: front end, sequence queue and byte serializer.
// ----------------------------------------------------------------------------
// Feed one UTF-16 code unit per word on the input channel, with last_unit set
// on the final unit of a string; take one UTF-8 byte per word on the output
// channel. A high surrogate that is not last produces no byte and is paired
// with the next unit whatever that unit is, giving four bytes; a lone
// surrogate at the end of a string, or a lone low surrogate, comes out as three
// bytes. The final byte of a string carries last_byte and the string's total
// byte count modulo 65536; byte_count reads zero on every other byte. Rate is
// set by the one-byte output channel: a code unit gives one to four UTF-8
// bytes (a held high surrogate gives none), and the serializer sends one byte
// every cycle while the queue holds work and out_ready is high. The input side
// accepts a unit every cycle while the FIFO_DEPTH entry sequence queue has
// room, so with out_ready held high a full input burst of ASCII runs at one
// word per cycle end to end. An accepted unit passes through the sequence
// queue and then the output register before its first byte shows.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder import utx_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic [15:0] byte_count
);

	// handshake between the parts
	logic       push;
	logic       pop;
	seq_t       push_seq;
	seq_t       head;
	fifo_stat_t fifo_stat;

	// classify units, hold high surrogates, encode whole code points
	utx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_seq  (push_seq)
	);

	// decouple input stalls from output stalls
	utx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_seq (push_seq),
		.pop      (pop),
		.head     (head),
		.stat     (fifo_stat)
	);

	// serialize bytes and count them per string
	utx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.byte_count (byte_count)
	);

`ifndef NO_ASSERTIONS
	// the count is only shown on the closing byte of a string
	a_count_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_byte |-> byte_count == 16'd0)
		else $error("byte_count nonzero on a byte that is not last");

	// a closing byte counts at least itself, up to wrap; one right after a closing byte counts only itself
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte && $past(out_valid && out_ready && last_byte)
		|-> byte_count == 16'd1)
		else $error("byte count not restarted after end of string");

	// queue can never be full and empty together
	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue reports full and empty at once");
`endif

endmodule

// ===== rtl/utx_front.sv =====
// ----------------------------------------------------------------------------
// utx_front - input side of the transcoder
// Accepts code units, pairs a held high surrogate with the following unit,
// and pushes each finished code point as an encoded byte sequence.
// ----------------------------------------------------------------------------
module utx_front import utx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	input  fifo_stat_t  fifo_stat,
	output logic        push,
	output seq_t        push_seq
);

	logic       pend_valid_q;
	logic [9:0] pend_high_q;
	logic       accept;
	logic       is_high;
	logic       hold;
	logic [20:0] cp;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign is_high  = (code_unit >= SURR_HIGH_FIRST) && (code_unit <= SURR_HIGH_LAST);
	assign hold     = !pend_valid_q && is_high && !last_unit;
	assign push     = accept && !hold;

	// combine without checking the second unit
	always_comb begin
		if (pend_valid_q) begin
			cp = {1'b0, pend_high_q, code_unit[9:0]} + PLANE_BASE;
		end else begin
			cp = {5'b00000, code_unit};
		end
		push_seq = encode_point(cp, last_unit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_high_q  <= '0;
		end else if (accept) begin
			pend_valid_q <= hold;
			pend_high_q  <= hold ? code_unit[9:0] : '0;
		end
	end

endmodule

// ===== rtl/utx_fifo.sv =====
// ----------------------------------------------------------------------------
// utx_fifo - short queue of encoded sequences between front and back
// ----------------------------------------------------------------------------
module utx_fifo import utx_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  seq_t       push_seq,
	input  logic       pop,
	output seq_t       head,
	output fifo_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(DEPTH);

	seq_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign stat.full  = (level_q == LVL_MAX);
	assign stat.empty = (level_q == '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/utx_back.sv =====
// ----------------------------------------------------------------------------
// utx_back - output side of the transcoder
// Walks the head sequence one byte per cycle, while the output is not stalled,
// into the output register and keeps the running byte count of the string.
// ----------------------------------------------------------------------------
module utx_back import utx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_t        head,
	input  fifo_stat_t  fifo_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic [15:0] byte_count
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_byte_q;
	logic [15:0] byte_count_q;
	logic [1:0]  idx_q;
	logic [15:0] count_q;
	logic        load;
	logic        seq_end;
	logic        str_end;
	logic [15:0] count_next;

	assign load       = !fifo_stat.empty && (!out_valid_q || out_ready);
	assign seq_end    = (idx_q == head.last_idx);
	assign str_end    = seq_end && head.last;
	assign pop        = load && seq_end;
	assign count_next = count_q + 16'd1;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;
	assign byte_count = byte_count_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.bytes[idx_q];
			last_byte_q  <= str_end;
			byte_count_q <= str_end ? count_next : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			count_q     <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= seq_end ? '0 : idx_q + 2'd1;
				count_q     <= str_end ? '0 : count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
